/* hdl/sal_pkg.sv */
// Package for the sentinel array list engine.
// Request, status and cell command codes shared by the top level, the cells
// and the checker. No dependencies.
package sal_pkg;

    // request codes as carried on i_req_type
    typedef enum logic [3:0] {
        REQ_CLEAR        = 4'd0,
        REQ_INSERT_AT    = 4'd1,
        REQ_INSERT_FIRST = 4'd2,
        REQ_INSERT_LAST  = 4'd3,
        REQ_DELETE_AT    = 4'd4,
        REQ_DELETE_FIRST = 4'd5,
        REQ_DELETE_LAST  = 4'd6,
        REQ_GET          = 4'd7,
        REQ_SET          = 4'd8,
        REQ_SEARCH       = 4'd9
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADIDX = 3'd3,
        ST_MARK   = 3'd4
    } t_status;

    // command broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_CLEAR      = 3'd1,
        OP_INSERT     = 3'd2,
        OP_DELETE     = 3'd3,
        OP_SET        = 3'd4,
        OP_SCAN_FIRST = 3'd5,
        OP_SCAN       = 3'd6
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     search;   // sweep looks for a value rather than an index
    } t_cell_ctl;

endpackage

/* hdl/sal_cell.sv */
// One slot of the list: holds a word and one stage of the sweep chain.
// Depends on sal_pkg.
module sal_cell #(
    parameter int          INDEX      = 0,
    parameter int          DATA_WIDTH = 16,
    parameter int          POS_WIDTH  = 7,
    parameter logic [DATA_WIDTH-1:0] MARK_WORD = '1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sal_pkg::t_cell_ctl    i_ctl,
    input  logic [POS_WIDTH-1:0]  i_pos,
    input  logic [POS_WIDTH-1:0]  i_count,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic [DATA_WIDTH-1:0] i_left_value,
    input  logic [DATA_WIDTH-1:0] i_right_value,
    input  logic                  i_left_hit,
    input  logic [DATA_WIDTH-1:0] i_left_sweep,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic                  o_hit,
    output logic [DATA_WIDTH-1:0] o_sweep
);

    localparam logic [POS_WIDTH-1:0] MY_IDX = POS_WIDTH'(INDEX);

    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic                  r_hit, n_hit;
    logic [DATA_WIDTH-1:0] r_sweep, n_sweep;
    logic                  hit;

    // index match for get, live value match for search
    assign hit = i_ctl.search ? ((MY_IDX < i_count) && (r_value == i_data))
                              : (MY_IDX == i_pos);

    always_comb begin
        n_value = r_value;
        n_hit   = r_hit;
        n_sweep = r_sweep;
        unique case (i_ctl.op)
            sal_pkg::OP_HOLD: begin
            end
            sal_pkg::OP_CLEAR: begin
                n_value = MARK_WORD;
            end
            sal_pkg::OP_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_value = i_data;
                end else if (MY_IDX > i_pos) begin
                    n_value = i_left_value;
                end
            end
            sal_pkg::OP_DELETE: begin
                if (MY_IDX >= i_pos) begin
                    n_value = i_right_value;
                end
            end
            sal_pkg::OP_SET: begin
                if (MY_IDX == i_pos) begin
                    n_value = i_data;
                end
            end
            sal_pkg::OP_SCAN_FIRST: begin
                n_hit   = hit;
                n_sweep = hit ? r_value : '0;
            end
            sal_pkg::OP_SCAN: begin
                n_hit   = hit | i_left_hit;
                n_sweep = hit ? r_value : i_left_sweep;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= MARK_WORD;
            r_hit   <= 1'b0;
        end else begin
            r_value <= n_value;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sweep <= n_sweep;
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;
    assign o_sweep = r_sweep;

endmodule

/* hdl/sentinel_array_list_engine.sv */
// Top level of the sentinel array list engine: request decode, length
// register, result registers and the row of sal_cell slots. Depends on sal_pkg.
//
// A request is taken when start is high and busy is low; its word appears on
// the o_ result ports with o_valid for exactly one cycle and cannot be held
// off. Clear, insert, delete, set, unused codes and every rejected request
// leave busy low: the result shows in the cycle after start and a new request
// may be issued in that same cycle, since all slots shift in parallel. A get
// with a valid index and every search hold busy high through S_SCAN and
// S_REPORT: hit flags and the matching word pass slot to slot along the row of
// cells, one slot per cycle; a get reports the word from the last cell, a
// search only its hit. After reset every slot holds the mark and the length count is zero at once.
module sentinel_array_list_engine #(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned DATA_WIDTH = 16,
    parameter int unsigned MARK_VALUE = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_req_type,
    input  logic [5:0]  i_position,
    input  logic [15:0] i_data_value,
    output logic        o_valid,
    output logic [15:0] o_read_value,
    output logic        o_found,
    output logic [6:0]  o_list_length,
    output logic [2:0]  o_status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam logic [DATA_WIDTH-1:0] MARK_WORD = DATA_WIDTH'(MARK_VALUE);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] SWEEP_LEN  = CW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_REPORT = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_left, n_left;
    logic [PW-1:0]         r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_search, n_search;
    logic                  r_valid, n_valid;
    logic [15:0]           r_read, n_read;
    logic                  r_found, n_found;
    logic [6:0]            r_length, n_length;
    sal_pkg::t_status      r_status, n_status;

    sal_pkg::t_cell_ctl    ctl;
    logic [PW-1:0]         cell_pos;
    logic [DATA_WIDTH-1:0] cell_data;

    logic                  accept;
    logic [PW-1:0]         pos_w, cnt_w, ins_pos, del_pos;
    logic [DATA_WIDTH-1:0] in_word;
    logic                  is_mark, is_full, is_empty;

    logic [DATA_WIDTH-1:0] value [CAPACITY];
    logic                  hit   [CAPACITY];
    logic [DATA_WIDTH-1:0] sweep [CAPACITY];

    assign accept   = start && !busy;
    assign pos_w    = PW'(i_position);
    assign cnt_w    = PW'(r_count);
    assign in_word  = DATA_WIDTH'(i_data_value);
    assign is_mark  = (in_word == MARK_WORD);
    assign is_full  = (r_count == FULL_COUNT);
    assign is_empty = (r_count == '0);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_left     = r_left;
        n_pos      = r_pos;
        n_data     = r_data;
        n_search   = r_search;
        n_valid    = 1'b0;
        n_read     = r_read;
        n_found    = r_found;
        n_length   = r_length;
        n_status   = r_status;
        ctl.op     = sal_pkg::OP_HOLD;
        ctl.search = r_search;
        cell_pos   = r_pos;
        cell_data  = r_data;
        ins_pos    = pos_w;
        del_pos    = pos_w;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cell_pos   = pos_w;
                    cell_data  = in_word;
                    ctl.search = 1'b0;
                    n_pos      = pos_w;
                    n_data     = in_word;
                    n_search   = 1'b0;
                    n_valid    = 1'b1;
                    n_read     = '0;
                    n_found    = 1'b0;
                    n_status   = sal_pkg::ST_OK;

                    unique case (sal_pkg::t_req_type'(i_req_type))
                        sal_pkg::REQ_CLEAR: begin
                            ctl.op  = sal_pkg::OP_CLEAR;
                            n_count = '0;
                        end
                        sal_pkg::REQ_INSERT_AT,
                        sal_pkg::REQ_INSERT_FIRST,
                        sal_pkg::REQ_INSERT_LAST: begin
                            if (i_req_type == sal_pkg::REQ_INSERT_FIRST) begin
                                ins_pos = '0;
                            end else if (i_req_type == sal_pkg::REQ_INSERT_LAST) begin
                                ins_pos = cnt_w;
                            end
                            cell_pos = ins_pos;
                            if (is_mark) begin
                                n_status = sal_pkg::ST_MARK;
                            end else if (is_full) begin
                                n_status = sal_pkg::ST_FULL;
                            end else if (ins_pos > cnt_w) begin
                                n_status = sal_pkg::ST_BADIDX;
                            end else begin
                                ctl.op  = sal_pkg::OP_INSERT;
                                n_count = r_count + CW'(1);
                            end
                        end
                        sal_pkg::REQ_DELETE_AT,
                        sal_pkg::REQ_DELETE_FIRST,
                        sal_pkg::REQ_DELETE_LAST: begin
                            if (i_req_type == sal_pkg::REQ_DELETE_FIRST) begin
                                del_pos = '0;
                            end else if (i_req_type == sal_pkg::REQ_DELETE_LAST) begin
                                del_pos = cnt_w - PW'(1);
                            end
                            cell_pos = del_pos;
                            if (is_empty) begin
                                n_status = sal_pkg::ST_EMPTY;
                            end else if (del_pos >= cnt_w) begin
                                n_status = sal_pkg::ST_BADIDX;
                            end else begin
                                ctl.op  = sal_pkg::OP_DELETE;
                                n_count = r_count - CW'(1);
                            end
                        end
                        sal_pkg::REQ_GET: begin
                            if (pos_w >= cnt_w) begin
                                n_status = sal_pkg::ST_BADIDX;
                            end else begin
                                ctl.op  = sal_pkg::OP_SCAN_FIRST;
                                n_valid = 1'b0;
                                n_left  = SWEEP_LEN;
                                n_state = S_SCAN;
                            end
                        end
                        sal_pkg::REQ_SET: begin
                            if (is_mark) begin
                                n_status = sal_pkg::ST_MARK;
                            end else if (pos_w >= cnt_w) begin
                                n_status = sal_pkg::ST_BADIDX;
                            end else begin
                                ctl.op = sal_pkg::OP_SET;
                            end
                        end
                        sal_pkg::REQ_SEARCH: begin
                            ctl.op     = sal_pkg::OP_SCAN_FIRST;
                            ctl.search = 1'b1;
                            n_search   = 1'b1;
                            n_valid    = 1'b0;
                            n_left     = SWEEP_LEN;
                            n_state    = S_SCAN;
                        end
                        default: begin
                        end
                    endcase

                    n_length = 7'(n_count);
                end
            end
            S_SCAN: begin
                ctl.op = sal_pkg::OP_SCAN;
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                n_valid  = 1'b1;
                n_read   = r_search ? 16'd0 : 16'(sweep[CAPACITY-1]);
                n_found  = r_search & hit[CAPACITY-1];
                n_length = 7'(r_count);
                n_status = sal_pkg::ST_OK;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_search <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_search <= n_search;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_data   <= n_data;
        r_read   <= n_read;
        r_found  <= n_found;
        r_length <= n_length;
        r_status <= n_status;
    end

    // row of slots; neighbours feed shifts and the sweep chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_value, right_value, left_sweep;
        logic                  left_hit;

        if (g == 0) begin : g_head
            assign left_value = MARK_WORD;
            assign left_hit   = 1'b0;
            assign left_sweep = '0;
        end else begin : g_body
            assign left_value = value[g-1];
            assign left_hit   = hit[g-1];
            assign left_sweep = sweep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_value = MARK_WORD;
        end else begin : g_inner
            assign right_value = value[g+1];
        end

        sal_cell #(
            .INDEX      (g),
            .DATA_WIDTH (DATA_WIDTH),
            .POS_WIDTH  (PW),
            .MARK_WORD  (MARK_WORD)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_pos         (cell_pos),
            .i_count       (cnt_w),
            .i_data        (cell_data),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .i_left_hit    (left_hit),
            .i_left_sweep  (left_sweep),
            .o_value       (value[g]),
            .o_hit         (hit[g]),
            .o_sweep       (sweep[g])
        );
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_read_value  = r_read;
    assign o_found       = r_found;
    assign o_list_length = r_length;
    assign o_status      = r_status;

endmodule

/* hdl/sal_checker.sv */
// Port-level checks for sentinel_array_list_engine, bound to the top level.
// Depends on sal_pkg.
module sal_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [15:0] o_read_value,
    input logic        o_found,
    input logic [6:0]  o_list_length,
    input logic [2:0]  o_status
);

    // a taken request either answers next cycle or starts a sweep
    a_accept_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("request neither answered nor swept");

    // no word may come out while a sweep is only just starting
    a_sweep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_valid)
        else $error("result word at sweep start");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != sal_pkg::ST_OK) |-> (o_read_value == 16'd0 && !o_found))
        else $error("rejected request carries data");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == sal_pkg::ST_OK && o_read_value == 16'd0))
        else $error("search hit with bad status or data");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == sal_pkg::ST_EMPTY) |-> (o_list_length == 7'd0))
        else $error("empty status with non-zero length");

endmodule

bind sentinel_array_list_engine sal_checker u_sal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_read_value  (o_read_value),
    .o_found       (o_found),
    .o_list_length (o_list_length),
    .o_status      (o_status)
);

/* tb/sv/tb_sentinel_array_list_engine.sv */
// Self-checking testbench for sentinel_array_list_engine: directed corner words,
// then random list traffic checked against a scoreboard that models the list.
// Depends on sal_pkg and the engine RTL.
`timescale 1ns / 1ps

localparam int unsigned  LIST_CAP  = 64;
localparam logic [15:0]  MARK_WORD = 16'hFFFF;

typedef struct {
    logic [3:0]       req;
    logic [15:0]      read_value;
    logic             found;
    logic [6:0]       list_length;
    sal_pkg::t_status status;
} t_list_outcome;

class list_scoreboard;
    logic [15:0]   slots [LIST_CAP];
    int unsigned   live_len;
    t_list_outcome pending [$];
    int unsigned   errors;

    function new();
        errors = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (slots[j]) slots[j] = MARK_WORD;
        live_len = 0;
    endfunction

    task report(string what);
        if (errors < 100) $display("MISMATCH @%0t: %s", $realtime, what);
        errors++;
    endtask

    function sal_pkg::t_status put_at(int unsigned p, logic [15:0] v);
        if (v == MARK_WORD) return sal_pkg::ST_MARK;
        if (live_len >= LIST_CAP) return sal_pkg::ST_FULL;
        if (p > live_len) return sal_pkg::ST_BADIDX;
        for (int unsigned j = live_len; j > p; j--) slots[j] = slots[j - 1];
        slots[p] = v;
        live_len++;
        return sal_pkg::ST_OK;
    endfunction

    function sal_pkg::t_status take_at(int unsigned p);
        if (live_len == 0) return sal_pkg::ST_EMPTY;
        if (p >= live_len) return sal_pkg::ST_BADIDX;
        for (int unsigned j = p; j + 1 < live_len; j++) slots[j] = slots[j + 1];
        live_len--;
        slots[live_len] = MARK_WORD;
        return sal_pkg::ST_OK;
    endfunction

    // called once per accepted request word; updates the list model
    function void note(logic [3:0] req, logic [5:0] pos, logic [15:0] val);
        t_list_outcome e;
        e.req        = req;
        e.read_value = '0;
        e.found      = 1'b0;
        e.status     = sal_pkg::ST_OK;
        case (req)
            sal_pkg::REQ_CLEAR:        wipe();
            sal_pkg::REQ_INSERT_AT:    e.status = put_at(pos, val);
            sal_pkg::REQ_INSERT_FIRST: e.status = put_at(0, val);
            sal_pkg::REQ_INSERT_LAST:  e.status = put_at(live_len, val);
            sal_pkg::REQ_DELETE_AT:    e.status = take_at(pos);
            sal_pkg::REQ_DELETE_FIRST: e.status = take_at(0);
            sal_pkg::REQ_DELETE_LAST:
                e.status = (live_len == 0) ? sal_pkg::ST_EMPTY : take_at(live_len - 1);
            sal_pkg::REQ_GET: begin
                if (pos >= live_len) e.status = sal_pkg::ST_BADIDX;
                else e.read_value = slots[pos];
            end
            sal_pkg::REQ_SET: begin
                if (val == MARK_WORD) e.status = sal_pkg::ST_MARK;
                else if (pos >= live_len) e.status = sal_pkg::ST_BADIDX;
                else slots[pos] = val;
            end
            sal_pkg::REQ_SEARCH: begin
                for (int unsigned j = 0; j < live_len; j++) begin
                    if (slots[j] == val) begin
                        e.found = 1'b1;
                        break;
                    end
                end
            end
            default: ;  // unused codes do nothing
        endcase
        e.list_length = live_len[6:0];
        pending.push_back(e);
    endfunction

    task check(logic [15:0] rd, logic fnd, logic [6:0] len, logic [2:0] st);
        t_list_outcome e;
        if (pending.size() == 0) begin
            report($sformatf("result word with nothing outstanding (len %0d st %0d)", len, st));
            return;
        end
        e = pending.pop_front();
        if (rd !== e.read_value)
            report($sformatf("req %0d read_value %h, want %h", e.req, rd, e.read_value));
        if (fnd !== e.found)
            report($sformatf("req %0d found %b, want %b", e.req, fnd, e.found));
        if (len !== e.list_length)
            report($sformatf("req %0d list_length %0d, want %0d", e.req, len, e.list_length));
        if (st !== e.status)
            report($sformatf("req %0d status %0d, want %0d", e.req, st, e.status));
    endtask
endclass

module tb_sentinel_array_list_engine;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RAND_ITEMS  = 800;

    localparam int unsigned MODE_GROW   = 0;
    localparam int unsigned MODE_SHRINK = 1;
    localparam int unsigned MODE_MIXED  = 2;
    localparam int unsigned MODE_NOISE  = 5;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_req_type;
    logic [5:0]  i_position;
    logic [15:0] i_data_value;
    logic        o_valid;
    logic [15:0] o_read_value;
    logic        o_found;
    logic [6:0]  o_list_length;
    logic [2:0]  o_status;

    list_scoreboard sb;
    int unsigned    stall_cycles;
    int unsigned    words_sent;
    bit             no_gaps;

    sentinel_array_list_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_position    (i_position),
        .i_data_value  (i_data_value),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_found       (o_found),
        .o_list_length (o_list_length),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result monitor and idle counter for the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check(o_read_value, o_found, o_list_length, o_status);
        if ((start && !busy) || o_valid === 1'b1) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // mostly short gaps, a few long; fields carry junk while start is low
    task automatic idle_gap();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 40);
        if (n > 0) begin
            start        <= 1'b0;
            i_req_type   <= 4'($urandom);
            i_position   <= 6'($urandom);
            i_data_value <= 16'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic issue(logic [3:0] req, logic [5:0] pos, logic [15:0] val);
        idle_gap();
        start        <= 1'b1;
        i_req_type   <= req;
        i_position   <= pos;
        i_data_value <= val;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note(req, pos, val);
        words_sent++;
    endtask

    function automatic logic [15:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) return MARK_WORD;
        if (r < 45) return 16'($urandom_range(0, 15));  // small pool so searches hit
        if (r < 50) return 16'hFFFE;
        return 16'($urandom);
    endfunction

    function automatic logic [5:0] pick_position();
        int unsigned r;
        int unsigned len;
        len = sb.live_len;
        r   = $urandom_range(0, 99);
        if (r < 65) return 6'($urandom_range(0, (len > 63) ? 63 : len));
        if (r < 75) return 6'(len);
        if (r < 85) return 6'((len == 0) ? 0 : len - 1);
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [3:0] pick_req(int unsigned mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                if (r < 60)
                    return 4'($urandom_range(sal_pkg::REQ_INSERT_AT, sal_pkg::REQ_INSERT_LAST));
                if (r < 82)
                    return 4'($urandom_range(sal_pkg::REQ_GET, sal_pkg::REQ_SEARCH));
                return 4'($urandom_range(sal_pkg::REQ_DELETE_AT, sal_pkg::REQ_DELETE_LAST));
            end
            MODE_SHRINK: begin
                if (r < 60)
                    return 4'($urandom_range(sal_pkg::REQ_DELETE_AT, sal_pkg::REQ_DELETE_LAST));
                if (r < 82)
                    return 4'($urandom_range(sal_pkg::REQ_GET, sal_pkg::REQ_SEARCH));
                return 4'($urandom_range(sal_pkg::REQ_INSERT_AT, sal_pkg::REQ_INSERT_LAST));
            end
            MODE_MIXED: begin
                if (r < 2) return sal_pkg::REQ_CLEAR;
                if (r < 36)
                    return 4'($urandom_range(sal_pkg::REQ_INSERT_AT, sal_pkg::REQ_INSERT_LAST));
                if (r < 66)
                    return 4'($urandom_range(sal_pkg::REQ_DELETE_AT, sal_pkg::REQ_DELETE_LAST));
                return 4'($urandom_range(sal_pkg::REQ_GET, sal_pkg::REQ_SEARCH));
            end
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        int unsigned mode;
        int unsigned burst;
        sb           = new();
        stall_cycles = 0;
        words_sent   = 0;
        no_gaps      = 1'b0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_req_type   <= '0;
        i_position   <= '0;
        i_data_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list rejections, ordering, append at length, unused codes
        issue(sal_pkg::REQ_CLEAR,        6'd0,  16'h0000);
        issue(sal_pkg::REQ_INSERT_LAST,  6'd0,  MARK_WORD);
        issue(sal_pkg::REQ_DELETE_FIRST, 6'd0,  16'h0000);
        issue(sal_pkg::REQ_DELETE_LAST,  6'd0,  16'h0000);
        issue(sal_pkg::REQ_DELETE_AT,    6'd0,  16'h0000);
        issue(sal_pkg::REQ_GET,          6'd0,  16'h0000);
        issue(sal_pkg::REQ_SET,          6'd0,  MARK_WORD);
        issue(sal_pkg::REQ_SEARCH,       6'd0,  MARK_WORD);
        issue(sal_pkg::REQ_INSERT_AT,    6'd1,  16'h0001);
        issue(sal_pkg::REQ_INSERT_AT,    6'd0,  16'h0000);
        issue(sal_pkg::REQ_INSERT_FIRST, 6'd63, 16'hFFFE);
        issue(sal_pkg::REQ_INSERT_LAST,  6'd0,  16'h1234);
        issue(sal_pkg::REQ_INSERT_AT,    6'd3,  16'h8001);
        issue(sal_pkg::REQ_GET,          6'd0,  16'h0000);
        issue(sal_pkg::REQ_GET,          6'd3,  16'h0000);
        issue(sal_pkg::REQ_SET,          6'd1,  16'h5A5A);
        issue(sal_pkg::REQ_SET,          6'd63, 16'h0002);
        issue(sal_pkg::REQ_SEARCH,       6'd0,  16'h5A5A);
        issue(sal_pkg::REQ_SEARCH,       6'd0,  16'h7777);
        issue(sal_pkg::REQ_DELETE_AT,    6'd1,  16'h0000);
        issue(sal_pkg::REQ_DELETE_AT,    6'd63, 16'h0000);
        issue(sal_pkg::REQ_DELETE_LAST,  6'd0,  16'h0000);
        issue(4'd10,                     6'd5,  16'hAAAA);
        issue(4'd15,                     6'd63, 16'hFFFF);
        issue(sal_pkg::REQ_DELETE_FIRST, 6'd0,  16'h0000);

        words_sent = 0;
        while (words_sent < RAND_ITEMS) begin
            mode    = $urandom_range(0, 9);
            burst   = $urandom_range(10, 40);
            no_gaps = ($urandom_range(0, 3) == 0);
            case (mode)
                0, 1: repeat (burst) issue(pick_req(MODE_GROW), pick_position(), pick_value());
                2, 3: repeat (burst) issue(pick_req(MODE_SHRINK), pick_position(), pick_value());
                4, 5, 9: repeat (burst)
                    issue(pick_req(MODE_MIXED), pick_position(), pick_value());
                6: begin
                    // run up to full, then knock on the full list
                    while (sb.live_len < LIST_CAP)
                        issue(4'($urandom_range(sal_pkg::REQ_INSERT_AT,
                                                sal_pkg::REQ_INSERT_LAST)),
                              pick_position(), pick_value());
                    repeat (3) issue(4'($urandom_range(sal_pkg::REQ_INSERT_AT,
                                                       sal_pkg::REQ_INSERT_LAST)),
                                     pick_position(), pick_value());
                    repeat (2) issue(pick_req(MODE_MIXED), pick_position(), pick_value());
                end
                7: begin
                    while (sb.live_len > 0)
                        issue(4'($urandom_range(sal_pkg::REQ_DELETE_AT,
                                                sal_pkg::REQ_DELETE_LAST)),
                              pick_position(), pick_value());
                    repeat (2) issue(4'($urandom_range(sal_pkg::REQ_DELETE_AT,
                                                       sal_pkg::REQ_DELETE_LAST)),
                                     pick_position(), pick_value());
                end
                default: repeat (burst)
                    issue(pick_req(MODE_NOISE), 6'($urandom), 16'($urandom));
            endcase
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LIST_CAP + 4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
